// ----- hw/rtl/smps_pkg.sv -----
package smps_pkg;

    // Job codes
    typedef enum logic [1:0] {
        JOB_NONE  = 2'd0,
        JOB_JOINT = 2'd1,
        JOB_WHEEL = 2'd2,
        JOB_PAUSE = 2'd3
    } job_t;

    // Command codes carried by command requests
    localparam logic [3:0] CMD_JOINT    = 4'd0;
    localparam logic [3:0] CMD_JRAMP    = 4'd1;
    localparam logic [3:0] CMD_WHEEL    = 4'd2;
    localparam logic [3:0] CMD_WRAMP    = 4'd3;
    localparam logic [3:0] CMD_DURATION = 4'd4;
    localparam logic [3:0] CMD_TAN_IN   = 4'd5;
    localparam logic [3:0] CMD_TAN_OUT  = 4'd6;
    localparam logic [3:0] CMD_MARGIN   = 4'd7;
    localparam logic [3:0] CMD_PAUSE    = 4'd8;

    // Divider geometry
    localparam int DVD_W = 64;
    localparam int DVS_W = 15;
    localparam int CNT_W = 6;

    // ceil(2**36 / 25): exact quotient by 25 for any 31-bit operand
    localparam logic [31:0] RCP25 = 32'd2748779070;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_EXEC,
        OP_B_DIV,
        OP_B_BTLD,
        OP_B_BB,
        OP_B_OI,
        OP_B_BO,
        OP_B_OS,
        OP_B_N,
        OP_B_NDIV,
        OP_B_T16,
        OP_B_BT,
        OP_B_F16,
        OP_B_FD,
        OP_B_GOAL,
        OP_W_LO,
        OP_W_HI,
        OP_W_SUM,
        OP_W_DIV,
        OP_W_FIN,
        OP_W_SPD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic path_bez;
        logic path_whl;
        logic div_done;
    } dp_stat_t;

endpackage

// ----- hw/rtl/servo_motion_profile_sequencer_top.sv -----
// A command request, or a tick that only checks or ends a task, runs ST_EXEC and then ST_OUT;
// a wheel ramp step runs ST_W_LO to ST_W_SPD between them, a Bezier step ST_B_DIV to ST_B_GOAL.
// Both long paths include one pass of the shared 64-step restoring divider.
// Throughput: one request at a time; the next is taken the cycle after the result is registered.
// Reset: aresetn is synchronous, active low; tasks clear, tangents 33/67, margin 4.
module servo_motion_profile_sequencer_top
    import smps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [3:0]         s_command,
    input  logic signed [15:0] s_value,
    input  logic [31:0]        s_now_ms,
    input  logic [9:0]         s_present_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_goal_write,
    output logic signed [15:0] m_goal_position,
    output logic               m_speed_write,
    output logic signed [15:0] m_wheel_speed,
    output logic               m_ready_res,
    output logic               m_idle
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    smps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    smps_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .s_mode             (s_mode),
        .s_command          (s_command),
        .s_value            (s_value),
        .s_now_ms           (s_now_ms),
        .s_present_position (s_present_position),
        .m_goal_write       (m_goal_write),
        .m_goal_position    (m_goal_position),
        .m_speed_write      (m_speed_write),
        .m_wheel_speed      (m_wheel_speed),
        .m_ready_res        (m_ready_res),
        .m_idle             (m_idle)
    );

endmodule

// ----- hw/rtl/smps_div.sv -----
module smps_div
    import smps_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    logic [DVD_W-1:0] dq_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DVS_W:0]   rem_sh;
    logic             ge;
    logic [DVS_W:0]   rem_sub;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh  = {rem_reg, dq_reg[DVD_W-1]};
        ge      = rem_sh >= {1'b0, dvs_reg};
        rem_sub = rem_sh - {1'b0, dvs_reg};
    end

    // Control: run one bit a cycle, pulse done after the last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {CNT_W{1'b1}}) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and shifting dividend / quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            dq_reg  <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (run_reg) begin
            dq_reg  <= {dq_reg[DVD_W-2:0], ge};
            rem_reg <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ----- hw/rtl/smps_ctrl.sv -----
module smps_ctrl
    import smps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [23:0] {
        ST_IDLE     = 24'h000001,
        ST_EXEC     = 24'h000002,
        ST_B_DIV    = 24'h000004,
        ST_B_DWAIT  = 24'h000008,
        ST_B_BTLD   = 24'h000010,
        ST_B_BB     = 24'h000020,
        ST_B_OI     = 24'h000040,
        ST_B_BO     = 24'h000080,
        ST_B_OS     = 24'h000100,
        ST_B_N      = 24'h000200,
        ST_B_NDIV   = 24'h000400,
        ST_B_T16    = 24'h000800,
        ST_B_BT     = 24'h001000,
        ST_B_F16    = 24'h002000,
        ST_B_FD     = 24'h004000,
        ST_B_GOAL   = 24'h008000,
        ST_W_LO     = 24'h010000,
        ST_W_HI     = 24'h020000,
        ST_W_SUM    = 24'h040000,
        ST_W_DIV    = 24'h080000,
        ST_W_DWAIT  = 24'h100000,
        ST_W_FIN    = 24'h200000,
        ST_W_SPD    = 24'h400000,
        ST_OUT      = 24'h800000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_load;
    dp_op_t op;

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Sequence the steps of one request
    always_comb begin
        state_next = state_reg;
        op         = OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                op = OP_EXEC;
                priority if (stat.path_bez) state_next = ST_B_DIV;
                else if (stat.path_whl)     state_next = ST_W_LO;
                else                        state_next = ST_OUT;
            end
            ST_B_DIV: begin
                op         = OP_B_DIV;
                state_next = ST_B_DWAIT;
            end
            ST_B_DWAIT: begin
                if (stat.div_done) state_next = ST_B_BTLD;
            end
            ST_B_BTLD: begin
                op         = OP_B_BTLD;
                state_next = ST_B_BB;
            end
            ST_B_BB: begin
                op         = OP_B_BB;
                state_next = ST_B_OI;
            end
            ST_B_OI: begin
                op         = OP_B_OI;
                state_next = ST_B_BO;
            end
            ST_B_BO: begin
                op         = OP_B_BO;
                state_next = ST_B_OS;
            end
            ST_B_OS: begin
                op         = OP_B_OS;
                state_next = ST_B_N;
            end
            ST_B_N: begin
                op         = OP_B_N;
                state_next = ST_B_NDIV;
            end
            ST_B_NDIV: begin
                op         = OP_B_NDIV;
                state_next = ST_B_T16;
            end
            ST_B_T16: begin
                op         = OP_B_T16;
                state_next = ST_B_BT;
            end
            ST_B_BT: begin
                op         = OP_B_BT;
                state_next = ST_B_F16;
            end
            ST_B_F16: begin
                op         = OP_B_F16;
                state_next = ST_B_FD;
            end
            ST_B_FD: begin
                op         = OP_B_FD;
                state_next = ST_B_GOAL;
            end
            ST_B_GOAL: begin
                op         = OP_B_GOAL;
                state_next = ST_OUT;
            end
            ST_W_LO: begin
                op         = OP_W_LO;
                state_next = ST_W_HI;
            end
            ST_W_HI: begin
                op         = OP_W_HI;
                state_next = ST_W_SUM;
            end
            ST_W_SUM: begin
                op         = OP_W_SUM;
                state_next = ST_W_DIV;
            end
            ST_W_DIV: begin
                op         = OP_W_DIV;
                state_next = ST_W_DWAIT;
            end
            ST_W_DWAIT: begin
                if (stat.div_done) state_next = ST_W_FIN;
            end
            ST_W_FIN: begin
                op         = OP_W_FIN;
                state_next = ST_W_SPD;
            end
            ST_W_SPD: begin
                op         = OP_W_SPD;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign cmd = '{op: op, load: s_ready && s_valid, out_load: out_load};

    // Hold the result until it is taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load)     m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- hw/rtl/smps_dp.sv -----
module smps_dp
    import smps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic               s_mode,
    input  logic [3:0]         s_command,
    input  logic signed [15:0] s_value,
    input  logic [31:0]        s_now_ms,
    input  logic [9:0]         s_present_position,
    output logic               m_goal_write,
    output logic signed [15:0] m_goal_position,
    output logic               m_speed_write,
    output logic signed [15:0] m_wheel_speed,
    output logic               m_ready_res,
    output logic               m_idle
);

    // Latched request
    logic               mode_reg;
    logic [3:0]         cmdc_reg;
    logic signed [15:0] value_reg;
    logic [31:0]        now_reg;
    logic [9:0]         pos_reg;

    // Profiler state
    job_t               active_reg, active_next;
    job_t               armed_reg, armed_next;
    logic [31:0]        last_reg, last_next;
    logic [31:0]        elapsed_reg, elapsed_next;
    logic signed [15:0] dur_reg, dur_next;
    logic signed [15:0] start_reg, start_next;
    logic signed [15:0] dest_reg, dest_next;
    logic signed [15:0] target_reg, target_next;
    logic signed [31:0] speed_reg, speed_next;
    logic signed [15:0] tin_reg, tin_next;
    logic signed [15:0] tout_reg, tout_next;
    logic signed [15:0] margin_reg, margin_next;

    // Result under construction
    logic               gw_reg, gw_next;
    logic signed [15:0] goal_reg, goal_next;
    logic               sw_reg, sw_next;
    logic signed [15:0] spd_reg, spd_next;
    logic               rdy_reg, rdy_next;

    // Working registers
    logic [15:0]        bt_reg;
    logic [38:0]        t0_reg;
    logic signed [51:0] t1_reg;
    logic signed [51:0] phi_reg;
    logic signed [52:0] n_reg;
    logic signed [67:0] prod_reg;
    logic signed [33:0] t16_reg;
    logic signed [33:0] f16_reg;
    logic signed [33:0] diff_reg;
    logic [31:0]        dt_reg;
    logic [14:0]        fdt_reg;
    logic               neg_reg;
    logic [62:0]        rcp_reg;

    // Combinational helpers
    logic [31:0]        dt;
    logic [32:0]        el_sum;
    logic [31:0]        el_new;
    logic [14:0]        dur_pos;
    logic               dur_le0;
    logic               el_ge;
    logic signed [17:0] dg;
    logic signed [17:0] mg;
    logic               settled;
    logic [16:0]        ot;
    logic signed [16:0] dsd;
    logic signed [16:0] tout_raw;
    logic signed [32:0] spd_bias;
    logic signed [52:0] t1x;
    logic signed [52:0] t1_bias;
    logic signed [52:0] n_sum;
    logic [52:0]        n_mag;
    logic [62:0]        rcp_p;
    logic [33:0]        t16_mag;
    logic [63:0]        prod_mag;
    logic [63:0]        qs;
    logic signed [52:0] gsum;
    logic signed [52:0] gbias;
    logic signed [36:0] gtr;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [51:0] mul_p;
    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_q;

    smps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_q)
    );

    // Tick timing and task decisions
    always_comb begin
        dt      = now_reg - last_reg;
        el_sum  = {1'b0, elapsed_reg} + {1'b0, dt};
        el_new  = el_sum[32] ? 32'hFFFF_FFFF : el_sum[31:0];
        dur_pos = dur_reg[15] ? 15'd0 : dur_reg[14:0];
        dur_le0 = dur_reg[15] || (dur_reg == 16'sd0);
        el_ge   = el_new >= {17'd0, dur_pos};
        dg      = 18'(target_reg) - $signed({8'd0, pos_reg});
        mg      = 18'(margin_reg);
        settled = !((dg > mg) || (dg < -mg));
        ot      = 17'h10000 - {1'b0, bt_reg};
        dsd     = 17'(dest_reg) - 17'(start_reg);
        tout_raw = 17'sd100 - 17'(value_reg);
        spd_bias = 33'(speed_reg) + (speed_reg[31] ? 33'sd65535 : 33'sd0);
    end

    assign stat.path_bez = mode_reg && (active_reg == JOB_JOINT) && !dur_le0 && !el_ge;
    assign stat.path_whl = mode_reg && (active_reg == JOB_WHEEL) && !el_ge;
    assign stat.div_done = div_done;

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_B_BB: begin
                mul_a = {18'd0, bt_reg};
                mul_b = {2'd0, bt_reg};
            end
            OP_B_OI: begin
                mul_a = 34'(tin_reg);
                mul_b = {1'b0, ot};
            end
            OP_B_BO: begin
                mul_a = 34'(tout_reg);
                mul_b = {2'd0, bt_reg};
            end
            OP_B_OS: begin
                mul_a = t1_reg[33:0];
                mul_b = {1'b0, ot};
            end
            OP_B_BT: begin
                mul_a = t16_reg;
                mul_b = {2'd0, bt_reg};
            end
            OP_B_FD: begin
                mul_a = f16_reg;
                mul_b = 18'(dsd);
            end
            OP_W_LO: begin
                mul_a = diff_reg;
                mul_b = {2'd0, dt_reg[15:0]};
            end
            OP_W_HI: begin
                mul_a = diff_reg;
                mul_b = {2'd0, dt_reg[31:16]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 52'(mul_a * mul_b);
    end

    // Wide sums, magnitudes and truncating shifts
    always_comb begin
        t1x      = 53'(t1_reg);
        t1_bias  = t1x + (t1_reg[51] ? 53'sd65535 : 53'sd0);
        n_sum    = $signed({14'd0, t0_reg}) + t1x + (t1x <<< 1);
        n_mag    = n_reg[52] ? 53'(-n_reg) : 53'(n_reg);
        // |n| / (100 * 65536): drop 18 bits, then divide by 25 by reciprocal
        rcp_p    = 63'(n_mag[48:18]) * 63'(RCP25);
        t16_mag  = {7'd0, rcp_reg[62:36]};
        prod_mag = prod_reg[67] ? 64'(-prod_reg) : 64'(prod_reg);
        qs       = neg_reg ? 64'(-div_q) : div_q;
        gsum     = $signed({start_reg, 16'd0}) + t1x;
        gbias    = gsum + (gsum[52] ? 53'sd65535 : 53'sd0);
        gtr      = 37'(gbias >>> 16);
    end

    // Divider request
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        unique case (cmd.op)
            OP_B_DIV: begin
                div_start = 1'b1;
                div_dvd   = {33'd0, elapsed_reg[14:0], 16'd0};
                div_dvs   = dur_pos;
            end
            OP_W_DIV: begin
                div_start = 1'b1;
                div_dvd   = prod_mag;
                div_dvs   = fdt_reg;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // Profiler state and result update
    always_comb begin
        active_next  = active_reg;
        armed_next   = armed_reg;
        last_next    = last_reg;
        elapsed_next = elapsed_reg;
        dur_next     = dur_reg;
        start_next   = start_reg;
        dest_next    = dest_reg;
        target_next  = target_reg;
        speed_next   = speed_reg;
        tin_next     = tin_reg;
        tout_next    = tout_reg;
        margin_next  = margin_reg;
        gw_next      = gw_reg;
        goal_next    = goal_reg;
        sw_next      = sw_reg;
        spd_next     = spd_reg;
        rdy_next     = rdy_reg;
        unique case (cmd.op)
            OP_EXEC: begin
                gw_next  = 1'b0;
                goal_next = '0;
                sw_next  = 1'b0;
                spd_next = '0;
                rdy_next = 1'b0;
                if (!mode_reg) begin
                    unique case (cmdc_reg)
                        CMD_JOINT: begin
                            target_next = value_reg;
                            dur_next    = '0;
                            gw_next     = 1'b1;
                            goal_next   = value_reg;
                            active_next = JOB_JOINT;
                        end
                        CMD_JRAMP: begin
                            active_next = JOB_NONE;
                            start_next  = {6'd0, pos_reg};
                            dest_next   = value_reg;
                            target_next = value_reg;
                            armed_next  = JOB_JOINT;
                        end
                        CMD_WHEEL: begin
                            active_next = JOB_NONE;
                            speed_next  = {value_reg, 16'd0};
                            sw_next     = 1'b1;
                            spd_next    = value_reg;
                        end
                        CMD_WRAMP: begin
                            active_next = JOB_NONE;
                            start_next  = spd_bias[31:16];
                            dest_next   = value_reg;
                            armed_next  = JOB_WHEEL;
                        end
                        CMD_DURATION: begin
                            elapsed_next = '0;
                            dur_next     = value_reg;
                            active_next  = armed_reg;
                            armed_next   = JOB_NONE;
                        end
                        CMD_TAN_IN:  tin_next    = value_reg;
                        CMD_TAN_OUT: tout_next   = (tout_raw > 17'sd32767) ? 16'sd32767
                                                                             : tout_raw[15:0];
                        CMD_MARGIN:  margin_next = value_reg;
                        CMD_PAUSE: begin
                            elapsed_next = '0;
                            dur_next     = value_reg;
                            active_next  = JOB_PAUSE;
                        end
                        default: begin
                            active_next = active_reg;
                        end
                    endcase
                end else begin
                    last_next = now_reg;
                    unique case (active_reg)
                        JOB_JOINT: begin
                            if (dur_le0) begin
                                if (settled) begin
                                    active_next  = JOB_NONE;
                                    dur_next     = '0;
                                    elapsed_next = '0;
                                    rdy_next     = 1'b1;
                                end
                            end else if (el_ge) begin
                                gw_next      = 1'b1;
                                goal_next    = target_reg;
                                active_next  = JOB_NONE;
                                dur_next     = '0;
                                elapsed_next = '0;
                                rdy_next     = 1'b1;
                            end else begin
                                elapsed_next = el_new;
                            end
                        end
                        JOB_WHEEL: begin
                            if (el_ge) begin
                                speed_next   = {dest_reg, 16'd0};
                                sw_next      = 1'b1;
                                spd_next     = dest_reg;
                                active_next  = JOB_NONE;
                                dur_next     = '0;
                                elapsed_next = '0;
                                rdy_next     = 1'b1;
                            end else begin
                                elapsed_next = el_new;
                            end
                        end
                        JOB_PAUSE: begin
                            if (el_ge) begin
                                active_next  = JOB_NONE;
                                dur_next     = '0;
                                elapsed_next = '0;
                                rdy_next     = 1'b1;
                            end else begin
                                elapsed_next = el_new;
                            end
                        end
                        default: begin
                            active_next = JOB_NONE;
                        end
                    endcase
                end
            end
            OP_B_GOAL: begin
                gw_next = 1'b1;
                priority if (gtr > 37'sd32767)  goal_next = 16'sd32767;
                else if (gtr < -37'sd32768)     goal_next = -16'sd32768;
                else                            goal_next = gtr[15:0];
            end
            OP_W_FIN: begin
                speed_next = speed_reg + $signed(qs[31:0]);
            end
            OP_W_SPD: begin
                sw_next  = 1'b1;
                spd_next = spd_bias[31:16];
            end
            default: begin
                rdy_next = rdy_reg;
            end
        endcase
    end

    // Architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= JOB_NONE;
            armed_reg   <= JOB_NONE;
            last_reg    <= '0;
            elapsed_reg <= '0;
            dur_reg     <= '0;
            start_reg   <= '0;
            dest_reg    <= '0;
            target_reg  <= '0;
            speed_reg   <= '0;
            tin_reg     <= 16'sd33;
            tout_reg    <= 16'sd67;
            margin_reg  <= 16'sd4;
        end else begin
            active_reg  <= active_next;
            armed_reg   <= armed_next;
            last_reg    <= last_next;
            elapsed_reg <= elapsed_next;
            dur_reg     <= dur_next;
            start_reg   <= start_next;
            dest_reg    <= dest_next;
            target_reg  <= target_next;
            speed_reg   <= speed_next;
            tin_reg     <= tin_next;
            tout_reg    <= tout_next;
            margin_reg  <= margin_next;
        end
    end

    // Request latch, working registers and result
    always_ff @(posedge aclk) begin
        gw_reg   <= gw_next;
        goal_reg <= goal_next;
        sw_reg   <= sw_next;
        spd_reg  <= spd_next;
        rdy_reg  <= rdy_next;
        if (cmd.load) begin
            mode_reg  <= s_mode;
            cmdc_reg  <= s_command;
            value_reg <= s_value;
            now_reg   <= s_now_ms;
            pos_reg   <= s_present_position;
        end
        unique case (cmd.op)
            OP_EXEC: begin
                fdt_reg  <= dur_pos - elapsed_reg[14:0];
                diff_reg <= $signed({dest_reg[15], dest_reg, 16'd0}) - 34'(speed_reg);
                dt_reg   <= dt;
            end
            OP_B_BTLD: bt_reg  <= div_q[15:0];
            OP_B_BB:   t0_reg  <= {7'd0, mul_p[31:0]};
            OP_B_OI:   t1_reg  <= mul_p;
            OP_B_BO: begin
                t1_reg <= t1_reg + mul_p;
                t0_reg <= (t0_reg << 6) + (t0_reg << 5) + (t0_reg << 2);
            end
            OP_B_OS:   t1_reg  <= mul_p;
            OP_B_N:    n_reg   <= n_sum;
            OP_B_NDIV: begin
                neg_reg <= n_reg[52];
                rcp_reg <= rcp_p;
            end
            OP_B_T16:  t16_reg <= neg_reg ? -t16_mag : t16_mag;
            OP_B_BT:   t1_reg  <= mul_p;
            OP_B_F16:  f16_reg <= 34'(t1_bias >>> 16);
            OP_B_FD:   t1_reg  <= mul_p;
            OP_W_LO:   t1_reg  <= mul_p;
            OP_W_HI:   phi_reg <= mul_p;
            OP_W_SUM:  prod_reg <= $signed({phi_reg, 16'd0}) + 68'(t1_reg);
            OP_W_DIV:  neg_reg <= prod_reg[67];
            default: begin
                neg_reg <= neg_reg;
            end
        endcase
        if (cmd.out_load) begin
            m_goal_write    <= gw_reg;
            m_goal_position <= goal_reg;
            m_speed_write   <= sw_reg;
            m_wheel_speed   <= spd_reg;
            m_ready_res     <= rdy_reg;
            m_idle          <= (active_reg == JOB_NONE);
        end
    end

endmodule

// ----- tb/tb_servo_motion_profile_sequencer_top.sv -----
module tb_servo_motion_profile_sequencer_top
    import smps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic        mode;
        logic [3:0]  command;
        logic [15:0] value;
        logic [31:0] now_ms;
        logic [9:0]  pos;
    } motion_req_t;

    typedef struct {
        logic        goal_write;
        logic [15:0] goal_position;
        logic        speed_write;
        logic [15:0] wheel_speed;
        logic        ready_res;
        logic        idle;
    } motion_res_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [3:0]         s_command;
    logic signed [15:0] s_value;
    logic [31:0]        s_now_ms;
    logic [9:0]         s_present_position;
    logic               m_valid;
    logic               m_ready;
    logic               m_goal_write;
    logic signed [15:0] m_goal_position;
    logic               m_speed_write;
    logic signed [15:0] m_wheel_speed;
    logic               m_ready_res;
    logic               m_idle;

    servo_motion_profile_sequencer_top DUT (.*);

    // Predictor state
    job_t          p_active;
    job_t          p_armed;
    logic [31:0]   p_last_tick;
    logic [31:0]   p_elapsed;
    longint        p_duration;
    longint        p_start;
    longint        p_dest;
    longint        p_target;
    longint        p_speed;
    longint        p_tan_in;
    longint        p_tan_out;
    longint        p_margin;

    motion_req_t   pending_reqs[$];
    motion_res_t   expected_results[$];
    int            mismatches;
    int            results_seen;
    int            ticks_sent;
    int            items_pushed;
    bit            no_idling;
    bit            long_hold;
    bit            in_acc;
    logic [31:0]   clock_ms;

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint sext16(logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint eased_goal(longint el, longint dur);
        longint bt, ot, n, t16, f16, sum;
        bt  = (el * 65536) / dur;
        ot  = 65536 - bt;
        n   = 100 * bt * bt + 3 * ot * (ot * p_tan_in + bt * p_tan_out);
        t16 = (n / 100) / 65536;
        f16 = (bt * t16) / 65536;
        sum = p_start * 65536 + f16 * (p_dest - p_start);
        return sat16(sum / 65536);
    endfunction

    function automatic void reset_profile();
        p_active = JOB_NONE; p_armed = JOB_NONE;
        p_last_tick = 0; p_elapsed = 0; p_duration = 0;
        p_start = 0; p_dest = 0; p_target = 0; p_speed = 0;
        p_tan_in = 33; p_tan_out = 67; p_margin = 4;
    endfunction

    function automatic void end_task();
        p_active = JOB_NONE; p_duration = 0; p_elapsed = 0;
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Advance the profile by one request and return its result
    function automatic motion_res_t step_profile(motion_req_t r);
        motion_res_t res;
        longint v, pos, dur, diff, fdt;
        logic [31:0] dt, old;
        res = '{default: 0};
        v = sext16(r.value);
        pos = r.pos;
        if (!r.mode) begin
            case (r.command)
                CMD_JOINT: begin
                    p_target = v; p_duration = 0;
                    res.goal_write = 1; res.goal_position = v[15:0];
                    p_active = JOB_JOINT;
                end
                CMD_JRAMP: begin
                    p_active = JOB_NONE;
                    p_start = pos; p_dest = v; p_target = v;
                    p_armed = JOB_JOINT;
                end
                CMD_WHEEL: begin
                    p_active = JOB_NONE;
                    p_speed = v * 65536;
                    res.speed_write = 1; res.wheel_speed = v[15:0];
                end
                CMD_WRAMP: begin
                    p_active = JOB_NONE;
                    p_start = sat16(p_speed / 65536);
                    p_dest = v; p_armed = JOB_WHEEL;
                end
                CMD_DURATION: begin
                    p_elapsed = 0; p_duration = v;
                    p_active = p_armed; p_armed = JOB_NONE;
                end
                CMD_TAN_IN:  p_tan_in = v;
                CMD_TAN_OUT: p_tan_out = sat16(100 - v);
                CMD_MARGIN:  p_margin = v;
                CMD_PAUSE: begin
                    p_elapsed = 0; p_duration = v; p_active = JOB_PAUSE;
                end
                default: ;
            endcase
        end else begin
            dt = r.now_ms - p_last_tick;
            dur = (p_duration < 0) ? 0 : p_duration;
            old = p_elapsed;
            p_last_tick = r.now_ms;
            if (p_active == JOB_JOINT) begin
                if (p_duration < 1) begin
                    diff = p_target - pos;
                    if (!(diff > p_margin || diff < -p_margin)) begin
                        end_task(); res.ready_res = 1;
                    end
                end else begin
                    p_elapsed = add_sat(old, dt);
                    res.goal_write = 1;
                    if (longint'(p_elapsed) >= dur) begin
                        res.goal_position = p_target[15:0];
                        end_task(); res.ready_res = 1;
                    end else begin
                        v = eased_goal(longint'(p_elapsed), dur);
                        res.goal_position = v[15:0];
                    end
                end
            end else if (p_active == JOB_WHEEL) begin
                p_elapsed = add_sat(old, dt);
                res.speed_write = 1;
                if (longint'(p_elapsed) >= dur) begin
                    p_speed = p_dest * 65536;
                    res.wheel_speed = p_dest[15:0];
                    end_task(); res.ready_res = 1;
                end else begin
                    fdt = dur - longint'(old);
                    diff = p_dest * 65536 - p_speed;
                    v = p_speed + (diff * longint'(dt)) / fdt;
                    p_speed = longint'($signed(v[31:0]));
                    v = sat16(p_speed / 65536);
                    res.wheel_speed = v[15:0];
                end
            end else if (p_active == JOB_PAUSE) begin
                p_elapsed = add_sat(old, dt);
                if (longint'(p_elapsed) >= dur) begin
                    end_task(); res.ready_res = 1;
                end
            end
        end
        res.idle = (p_active == JOB_NONE);
        return res;
    endfunction

    function automatic void push_cmd(logic [3:0] c, logic [15:0] v, logic [9:0] p);
        motion_req_t r;
        r = '{mode: 0, command: c, value: v, now_ms: $urandom, pos: p};
        pending_reqs.push_back(r);
        items_pushed++;
    endfunction

    function automatic void push_tick(logic [31:0] t, logic [9:0] p);
        motion_req_t r;
        r = '{mode: 1, command: 4'($urandom), value: 16'($urandom), now_ms: t, pos: p};
        pending_reqs.push_back(r);
        ticks_sent++;
        items_pushed++;
    endfunction

    function automatic void push_ticks(int n, int maxstep);
        for (int i = 0; i < n; i++) begin
            clock_ms += $urandom_range(maxstep, 0);
            push_tick(clock_ms, 10'($urandom));
        end
    endfunction

    // Clock
    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    // Note whether the request on offer was taken at the last rising edge
    always @(posedge aclk) begin
        in_acc <= s_valid && s_ready;
    end

    // Driver: present requests at the falling edge
    int drv_gap;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_acc) begin
            // hold the request until taken
        end else if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            motion_req_t r;
            r = pending_reqs.pop_front();
            s_valid <= 1'b1;
            s_mode <= r.mode;
            s_command <= r.command;
            s_value <= r.value;
            s_now_ms <= r.now_ms;
            s_present_position <= r.pos;
            expected_results.push_back(step_profile(r));
            if (!no_idling && $urandom_range(5, 0) == 0) drv_gap <= $urandom_range(9, 1);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver back-pressure
    int rcv_gap;
    always @(negedge aclk) begin
        if (!aresetn || long_hold) begin
            m_ready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap <= rcv_gap - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!no_idling && $urandom_range(5, 0) == 0) rcv_gap <= $urandom_range(9, 1);
        end
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            motion_res_t e;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at %0t", $realtime);
            end else begin
                e = expected_results.pop_front();
                if (m_goal_write !== e.goal_write || m_goal_position !== e.goal_position ||
                    m_speed_write !== e.speed_write || m_wheel_speed !== e.wheel_speed ||
                    m_ready_res !== e.ready_res || m_idle !== e.idle) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch %0t: exp gw=%0d g=%0d sw=%0d s=%0d r=%0d i=%0d",
                                  " got gw=%0d g=%0d sw=%0d s=%0d r=%0d i=%0d"},
                            $realtime, e.goal_write, $signed(e.goal_position), e.speed_write,
                            $signed(e.wheel_speed), e.ready_res, e.idle, m_goal_write,
                            m_goal_position, m_speed_write, m_wheel_speed, m_ready_res, m_idle);
                end
            end
        end
    end

    // Long receiver hold while the sender keeps offering requests
    initial begin
        long_hold = 1'b0;
        wait (results_seen >= 300);
        @(negedge aclk);
        long_hold = 1'b1;
        repeat (2000) @(posedge aclk);
        long_hold = 1'b0;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("FAIL servo_motion_profile_sequencer_top");
        $finish;
    end

    // Stimulus and end of run
    initial begin
        int kind;
        int n;
        aresetn = 1'b0; s_valid = 1'b0; m_ready = 1'b0;
        s_mode = 0; s_command = 0; s_value = 0; s_now_ms = 0; s_present_position = 0;
        drv_gap = 0; rcv_gap = 0; mismatches = 0; results_seen = 0; ticks_sent = 0;
        items_pushed = 0; no_idling = 0; clock_ms = 0;
        reset_profile();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, every command, special cases
        push_cmd(CMD_JOINT, 16'h7FFF, 10'd0);
        push_tick(32'd5, 10'h3FF);
        push_cmd(CMD_JOINT, 16'h8000, 10'd0);
        push_cmd(CMD_MARGIN, 16'hFFFF, 10'd0);       // negative margin never settles
        push_tick(32'd6, 10'd0);
        push_cmd(CMD_MARGIN, 16'd4, 10'd0);
        push_cmd(CMD_JOINT, 16'd500, 10'd0);
        push_tick(32'd7, 10'd502);                   // settles within margin
        push_cmd(CMD_TAN_IN, 16'h7FFF, 10'd0);
        push_cmd(CMD_TAN_OUT, 16'h8000, 10'd0);      // 100 minus value saturates
        push_cmd(CMD_JRAMP, 16'h7FFF, 10'h3FF);
        push_cmd(CMD_DURATION, 16'd40, 10'd0);
        push_tick(32'd27, 10'd0);
        push_tick(32'd100, 10'd0);
        push_cmd(CMD_TAN_IN, 16'd33, 10'd0);
        push_cmd(CMD_TAN_OUT, 16'd33, 10'd0);
        push_cmd(CMD_WHEEL, 16'h8000, 10'd0);
        push_cmd(CMD_WRAMP, 16'h7FFF, 10'd0);
        push_cmd(CMD_DURATION, 16'hFFF0, 10'd0);     // negative duration ends on next tick
        push_tick(32'hFFFF_FFF0, 10'd0);             // timestamp wraps
        push_cmd(CMD_PAUSE, 16'd3, 10'd0);
        push_tick(32'd2, 10'd0);
        push_cmd(CMD_DURATION, 16'd10, 10'd0);       // nothing armed
        push_cmd(4'd15, 16'h1234, 10'd0);            // unknown code ignored
        clock_ms = 32'd2;

        // Random: mostly well-formed move sequences with random content
        while (items_pushed < 1900) begin
            wait (pending_reqs.size() < 40);
            kind = $urandom_range(9, 0);
            n = $urandom_range(12, 1);
            case (kind)
                0, 1, 2: begin
                    if ($urandom_range(1, 0))
                        push_cmd(CMD_TAN_IN, 16'($urandom_range(100, 0)), 10'd0);
                    if ($urandom_range(1, 0))
                        push_cmd(CMD_TAN_OUT, 16'($urandom_range(100, 0)), 10'd0);
                    push_cmd(CMD_JRAMP, 16'($urandom), 10'($urandom));
                    push_cmd(CMD_DURATION, 16'($urandom_range(60, 1)), 10'd0);
                    push_ticks(n, 15);
                end
                3, 4: begin
                    if ($urandom_range(1, 0)) push_cmd(CMD_WHEEL, 16'($urandom), 10'd0);
                    push_cmd(CMD_WRAMP, 16'($urandom), 10'd0);
                    push_cmd(CMD_DURATION, 16'($urandom_range(60, 0)), 10'd0);
                    push_ticks(n, 15);
                end
                5: begin
                    push_cmd(CMD_PAUSE, 16'($urandom_range(30, 0)), 10'd0);
                    push_ticks(n, 10);
                end
                6: begin
                    push_cmd(CMD_MARGIN, 16'($urandom_range(20, 0)), 10'd0);
                    push_cmd(CMD_JOINT, 16'($urandom_range(1023, 0)), 10'd0);
                    push_ticks(n, 5);
                end
                7: begin
                    push_cmd(CMD_DURATION, 16'($urandom), 10'd0);
                    push_ticks(2, 40000);
                end
                default: begin
                    push_cmd(4'($urandom), 16'($urandom), 10'($urandom));
                    push_tick($urandom, 10'($urandom));
                end
            endcase
            if (items_pushed > 1700) no_idling = 1'b1;
        end

        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_results.size() == 0);
        repeat (300) @(posedge aclk);
        $display("Covered %0d results incl. %0d ticks:", results_seen, ticks_sent);
        $display("  joint eases, settle waits, wheel ramps, pauses, stalls.");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS servo_motion_profile_sequencer_top");
        end else begin
            $display("FAIL servo_motion_profile_sequencer_top");
        end
        $finish;
    end
endmodule

// ----- servo_motion_profile_sequencer_top.f -----
hw/rtl/smps_pkg.sv
hw/rtl/smps_div.sv
hw/rtl/smps_ctrl.sv
hw/rtl/smps_dp.sv
hw/rtl/servo_motion_profile_sequencer_top.sv
tb/tb_servo_motion_profile_sequencer_top.sv
